// ===== rtl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotation pipeline.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package qvr_pkg;

    // Width of every quaternion, vector and result component.
    localparam int DATA_W  = 16;
    // Product of two components, and the sum of three such products.
    localparam int PROD1_W = 2 * DATA_W;
    localparam int SUM1_W  = PROD1_W + 2;

    // Saturation limits of a result component.
    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef struct packed {
        t_sample w;
        t_sample x;
        t_sample y;
        t_sample z;
    } t_quat;

endpackage

`default_nettype wire

// ===== rtl/qvr_stage_one.sv =====
// First Hamilton product w = q * (0,v): a multiplier register stage then a
// sum, round and register stage. Depends on qvr_pkg.
`default_nettype none

module qvr_stage_one #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int W_W            = qvr_pkg::SUM1_W - QUAT_FRAC_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire qvr_pkg::t_quat         i_quat,
    input  wire qvr_pkg::t_sample       i_vec_x,
    input  wire qvr_pkg::t_sample       i_vec_y,
    input  wire qvr_pkg::t_sample       i_vec_z,
    output logic                        o_valid,
    output logic signed [W_W-1:0]       o_w [4],
    output qvr_pkg::t_quat              o_quat
);

    import qvr_pkg::*;

    localparam logic signed [SUM1_W-1:0] RND = SUM1_W'(1) <<< (QUAT_FRAC_BITS - 1);

    logic                      r_vld_a;
    logic                      r_vld_b;
    t_quat                     r_quat_a;
    t_quat                     r_quat_b;
    logic signed [PROD1_W-1:0] r_p [12];
    logic signed [W_W-1:0]     r_w [4];

    logic signed [SUM1_W-1:0]  n_s0;
    logic signed [SUM1_W-1:0]  n_s1;
    logic signed [SUM1_W-1:0]  n_s2;
    logic signed [SUM1_W-1:0]  n_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    // One multiplier per register: all twelve partial products in parallel.
    always_ff @(posedge i_clk) begin
        r_quat_a <= i_quat;
        r_p[0]   <= i_quat.x * i_vec_x;
        r_p[1]   <= i_quat.y * i_vec_y;
        r_p[2]   <= i_quat.z * i_vec_z;
        r_p[3]   <= i_quat.w * i_vec_x;
        r_p[4]   <= i_quat.y * i_vec_z;
        r_p[5]   <= i_quat.z * i_vec_y;
        r_p[6]   <= i_quat.w * i_vec_y;
        r_p[7]   <= i_quat.x * i_vec_z;
        r_p[8]   <= i_quat.z * i_vec_x;
        r_p[9]   <= i_quat.w * i_vec_z;
        r_p[10]  <= i_quat.x * i_vec_y;
        r_p[11]  <= i_quat.y * i_vec_x;
    end

    // Exact sums with the rounding half added; taking the upper bits is a floor shift.
    always_comb begin
        n_s0 = RND - SUM1_W'(r_p[0]) - SUM1_W'(r_p[1]) - SUM1_W'(r_p[2]);
        n_s1 = RND + SUM1_W'(r_p[3]) + SUM1_W'(r_p[4]) - SUM1_W'(r_p[5]);
        n_s2 = RND + SUM1_W'(r_p[6]) - SUM1_W'(r_p[7]) + SUM1_W'(r_p[8]);
        n_s3 = RND + SUM1_W'(r_p[9]) + SUM1_W'(r_p[10]) - SUM1_W'(r_p[11]);
    end

    always_ff @(posedge i_clk) begin
        r_quat_b <= r_quat_a;
        r_w[0]   <= n_s0[SUM1_W-1:QUAT_FRAC_BITS];
        r_w[1]   <= n_s1[SUM1_W-1:QUAT_FRAC_BITS];
        r_w[2]   <= n_s2[SUM1_W-1:QUAT_FRAC_BITS];
        r_w[3]   <= n_s3[SUM1_W-1:QUAT_FRAC_BITS];
    end

    assign o_valid = r_vld_b;
    assign o_w     = r_w;
    assign o_quat  = r_quat_b;

endmodule

`default_nettype wire

// ===== rtl/qvr_stage_two.sv =====
// Second Hamilton product r = w * conj(q), vector part, with rounding and
// saturation to 16 bits: a multiplier stage then a sum and output stage. Depends on qvr_pkg.
`default_nettype none

module qvr_stage_two #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int W_W            = qvr_pkg::SUM1_W - QUAT_FRAC_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic signed [W_W-1:0]  i_w [4],
    input  wire qvr_pkg::t_quat         i_quat,
    output logic                        o_valid,
    output qvr_pkg::t_sample            o_rot_x,
    output qvr_pkg::t_sample            o_rot_y,
    output qvr_pkg::t_sample            o_rot_z
);

    import qvr_pkg::*;

    localparam int PW     = W_W + DATA_W;
    localparam int SUM2_W = (PW + 3 > QUAT_FRAC_BITS + 2) ? PW + 3 : QUAT_FRAC_BITS + 2;
    localparam int RW     = SUM2_W - QUAT_FRAC_BITS;
    localparam int EW     = (RW > DATA_W + 1) ? RW : DATA_W + 1;

    localparam logic signed [SUM2_W-1:0] RND  = SUM2_W'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam logic signed [EW-1:0]     MAXE = EW'(SAT_MAX);
    localparam logic signed [EW-1:0]     MINE = EW'(SAT_MIN);

    logic                     r_vld_c;
    logic                     r_vld_d;
    logic signed [PW-1:0]     r_q [12];
    t_sample                  r_rot [3];

    logic signed [SUM2_W-1:0] n_s [3];
    logic signed [RW-1:0]     n_r [3];
    logic signed [EW-1:0]     n_e [3];
    t_sample                  n_rot [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            r_vld_c <= i_valid;
            r_vld_d <= r_vld_c;
        end
    end

    // The conjugate's signs are folded into the sums below.
    always_ff @(posedge i_clk) begin
        r_q[0]  <= i_w[0] * i_quat.x;
        r_q[1]  <= i_w[1] * i_quat.w;
        r_q[2]  <= i_w[2] * i_quat.z;
        r_q[3]  <= i_w[3] * i_quat.y;
        r_q[4]  <= i_w[0] * i_quat.y;
        r_q[5]  <= i_w[1] * i_quat.z;
        r_q[6]  <= i_w[2] * i_quat.w;
        r_q[7]  <= i_w[3] * i_quat.x;
        r_q[8]  <= i_w[0] * i_quat.z;
        r_q[9]  <= i_w[1] * i_quat.y;
        r_q[10] <= i_w[2] * i_quat.x;
        r_q[11] <= i_w[3] * i_quat.w;
    end

    always_comb begin
        n_s[0] = RND - SUM2_W'(r_q[0]) + SUM2_W'(r_q[1])
               - SUM2_W'(r_q[2]) + SUM2_W'(r_q[3]);
        n_s[1] = RND - SUM2_W'(r_q[4]) + SUM2_W'(r_q[5])
               + SUM2_W'(r_q[6]) - SUM2_W'(r_q[7]);
        n_s[2] = RND - SUM2_W'(r_q[8]) - SUM2_W'(r_q[9])
               + SUM2_W'(r_q[10]) + SUM2_W'(r_q[11]);
        for (int i = 0; i < 3; i++) begin
            n_r[i] = n_s[i][SUM2_W-1:QUAT_FRAC_BITS];
            n_e[i] = EW'(n_r[i]);
            if (n_e[i] > MAXE) begin
                n_rot[i] = t_sample'(SAT_MAX);
            end else if (n_e[i] < MINE) begin
                n_rot[i] = t_sample'(SAT_MIN);
            end else begin
                n_rot[i] = n_e[i][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_valid = r_vld_d;
    assign o_rot_x = r_rot[0];
    assign o_rot_y = r_rot[1];
    assign o_rot_z = r_rot[2];

endmodule

`default_nettype wire

// ===== rtl/quaternion_vector_rotate.sv =====
// Quaternion vector rotation top level: ties the two Hamilton product stages together.
// Depends on qvr_pkg, qvr_stage_one and qvr_stage_two.
`default_nettype none

// Rotates (i_vec_x, i_vec_y, i_vec_z) by the quaternion (i_quat_w .. i_quat_z), given in
// signed fixed point with QUAT_FRAC_BITS fraction bits, as q * (0,v) * conj(q). A beat is
// taken at every clock edge with start high; busy is always low, so one vector enters per
// cycle. Each result is shown for one cycle with o_valid high, after passing through two
// register stages for each Hamilton product, a multiplier rank followed by an adder,
// round and register rank. Both products round half upwards; the final components
// saturate to 16 bits. The quaternion is not normalised, so the result scales with |q|^2.
module quaternion_vector_rotate #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire qvr_pkg::t_sample i_quat_w,
    input  wire qvr_pkg::t_sample i_quat_x,
    input  wire qvr_pkg::t_sample i_quat_y,
    input  wire qvr_pkg::t_sample i_quat_z,
    input  wire qvr_pkg::t_sample i_vec_x,
    input  wire qvr_pkg::t_sample i_vec_y,
    input  wire qvr_pkg::t_sample i_vec_z,
    output logic                  o_valid,
    output qvr_pkg::t_sample      o_rot_x,
    output qvr_pkg::t_sample      o_rot_y,
    output qvr_pkg::t_sample      o_rot_z
);

    import qvr_pkg::*;

    localparam int W_W = SUM1_W - QUAT_FRAC_BITS;

    t_quat                 quat_in;
    t_quat                 quat_mid;
    logic                  vld_mid;
    logic signed [W_W-1:0] w_mid [4];

    assign busy    = 1'b0;
    assign quat_in = '{w: i_quat_w, x: i_quat_x, y: i_quat_y, z: i_quat_z};

    qvr_stage_one #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .W_W            (W_W)
    ) u_stage_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_quat  (quat_in),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .o_valid (vld_mid),
        .o_w     (w_mid),
        .o_quat  (quat_mid)
    );

    qvr_stage_two #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .W_W            (W_W)
    ) u_stage_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_mid),
        .i_w     (w_mid),
        .i_quat  (quat_mid),
        .o_valid (o_valid),
        .o_rot_x (o_rot_x),
        .o_rot_y (o_rot_y),
        .o_rot_z (o_rot_z)
    );

`ifndef ASSERT_OFF
    // Every accepted beat yields its result strobe once it has passed through the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("result strobe missing four cycles after an accepted beat");

    // No result appears without an earlier accepted beat to match it.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result strobe without a matching accepted beat");

    // A zero vector must rotate to zero whatever the quaternion.
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_vec_x == 16'sd0 && i_vec_y == 16'sd0 && i_vec_z == 16'sd0)
        |-> ##4 (o_rot_x == 16'sd0 && o_rot_y == 16'sd0 && o_rot_z == 16'sd0))
        else $error("zero vector did not give a zero result");
`endif

endmodule

`default_nettype wire

// ===== test/quaternion_vector_rotate_tb.sv =====
// Self-checking testbench for quaternion_vector_rotate: bursts of rotation beats in,
// results compared against an in-bench fixed-point model. Depends on qvr_pkg and the RTL.
`default_nettype none

module quaternion_vector_rotate_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    localparam int QUAT_FRAC = 14;
    localparam int UNIT      = 1 << QUAT_FRAC;
    localparam int COS45     = 11585;

    typedef struct packed {
        t_sample x;
        t_sample y;
        t_sample z;
    } t_vec3;

    typedef struct packed {
        t_quat q;
        t_vec3 v;
    } t_beat;

    // Holds the rotations still owed by the block, oldest first.
    class rotation_scoreboard;
        t_vec3 pending_rotations[$];
        int    mismatches;
        int    unexpected;

        static function longint round_q(longint v);
            return (v + (longint'(1) <<< (QUAT_FRAC - 1))) >>> QUAT_FRAC;
        endfunction

        static function t_sample clamp16(longint v);
            if (v > SAT_MAX) return t_sample'(SAT_MAX);
            if (v < SAT_MIN) return t_sample'(SAT_MIN);
            return t_sample'(v);
        endfunction

        // q * (0,v) * conj(q); the first product is rounded but kept wide.
        static function t_vec3 predict_rotation(t_quat q, t_vec3 v);
            longint a0, a1, a2, a3, vx, vy, vz;
            longint w0, w1, w2, w3;
            t_vec3  r;
            a0 = longint'($signed(q.w));
            a1 = longint'($signed(q.x));
            a2 = longint'($signed(q.y));
            a3 = longint'($signed(q.z));
            vx = longint'($signed(v.x));
            vy = longint'($signed(v.y));
            vz = longint'($signed(v.z));
            w0 = round_q(-a1 * vx - a2 * vy - a3 * vz);
            w1 = round_q(a0 * vx + a2 * vz - a3 * vy);
            w2 = round_q(a0 * vy - a1 * vz + a3 * vx);
            w3 = round_q(a0 * vz + a1 * vy - a2 * vx);
            r.x = clamp16(round_q(-w0 * a1 + w1 * a0 - w2 * a3 + w3 * a2));
            r.y = clamp16(round_q(-w0 * a2 + w1 * a3 + w2 * a0 - w3 * a1));
            r.z = clamp16(round_q(-w0 * a3 - w1 * a2 + w2 * a1 + w3 * a0));
            return r;
        endfunction

        function void note_beat(t_beat b);
            pending_rotations.push_back(predict_rotation(b.q, b.v));
        endfunction

        function void check_rotation(t_vec3 got);
            t_vec3 want;
            if (pending_rotations.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("[%0t] result with nothing outstanding: x=%0d y=%0d z=%0d",
                             $time, got.x, got.y, got.z);
                return;
            end
            want = pending_rotations.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("[%0t] rotation mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                             $time, want.x, want.y, want.z, got.x, got.y, got.z);
            end
        endfunction

        function int outstanding();
            return pending_rotations.size();
        endfunction

        function int failures();
            return mismatches + unexpected + pending_rotations.size();
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_sample i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    t_sample i_vec_x, i_vec_y, i_vec_z;
    logic    o_valid;
    t_sample o_rot_x, o_rot_y, o_rot_z;

    rotation_scoreboard sb = new();
    t_beat              directed_beats[$];

    quaternion_vector_rotate #(
        .QUAT_FRAC_BITS(QUAT_FRAC)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_quat_w(i_quat_w),
        .i_quat_x(i_quat_x),
        .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .o_valid (o_valid),
        .o_rot_x (o_rot_x),
        .o_rot_y (o_rot_y),
        .o_rot_z (o_rot_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Everything is driven with nonblocking assignments, so values read here are the
    // ones that stood before the edge. Inputs are noted before results are checked.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
            sb.note_beat('{'{i_quat_w, i_quat_x, i_quat_y, i_quat_z},
                           '{i_vec_x, i_vec_y, i_vec_z}});
        if (i_rst_n === 1'b1 && o_valid !== 1'b0)
            sb.check_rotation('{o_rot_x, o_rot_y, o_rot_z});
    end

    function automatic void add_directed(int w, int x, int y, int z, int vx, int vy, int vz);
        directed_beats.push_back('{'{t_sample'(w), t_sample'(x), t_sample'(y), t_sample'(z)},
                                   '{t_sample'(vx), t_sample'(vy), t_sample'(vz)}});
    endfunction

    function automatic t_sample rand_within(int m);
        return t_sample'(int'($urandom_range(2 * m)) - m);
    endfunction

    function automatic t_sample rand_corner();
        case ($urandom_range(6))
            0: return t_sample'(SAT_MIN);
            1: return t_sample'(SAT_MAX);
            2: return t_sample'(-1);
            3: return t_sample'(0);
            4: return t_sample'(1);
            5: return t_sample'(UNIT);
            default: return t_sample'(-UNIT);
        endcase
    endfunction

    // Random direction scaled to the given length in Q2.14 units.
    function automatic t_quat rand_scaled_quat(real len);
        real   a[4];
        real   norm;
        t_quat q;
        norm = 0.0;
        for (int i = 0; i < 4; i++) begin
            a[i] = real'(int'($urandom_range(65535)) - 32768);
            norm += a[i] * a[i];
        end
        norm = $sqrt(norm);
        if (norm < 1.0) return '{t_sample'(UNIT), '0, '0, '0};
        q.w = t_sample'(int'(a[0] * len / norm));
        q.x = t_sample'(int'(a[1] * len / norm));
        q.y = t_sample'(int'(a[2] * len / norm));
        q.z = t_sample'(int'(a[3] * len / norm));
        return q;
    endfunction

    // Half the beats are proper rotations; the rest are raw, small, oversized or corner values.
    function automatic t_beat random_beat();
        t_beat b;
        b.q = t_quat'({$urandom(), $urandom()});
        b.v = t_vec3'({$urandom(), $urandom()});
        case ($urandom_range(9))
            0, 1, 2, 3: b.q = rand_scaled_quat(real'(UNIT));
            4, 5: ;
            6: b.q = rand_scaled_quat(real'(UNIT) * (1.0 + real'($urandom_range(400)) / 1000.0));
            7: begin
                b.q = '{rand_within(64), rand_within(64), rand_within(64), rand_within(64)};
                b.v = '{rand_within(64), rand_within(64), rand_within(64)};
            end
            8: begin
                b.q = '{rand_corner(), rand_corner(), rand_corner(), rand_corner()};
                b.v = '{rand_corner(), rand_corner(), rand_corner()};
            end
            default: begin
                b.q = rand_scaled_quat(real'(UNIT));
                b.v = '{rand_within(300), rand_within(300), rand_within(300)};
            end
        endcase
        return b;
    endfunction

    // Called just after a rising edge; returns just after the edge that took the beat.
    task automatic send_beat(t_beat b);
        i_quat_w <= b.q.w;
        i_quat_x <= b.q.x;
        i_quat_y <= b.q.y;
        i_quat_z <= b.q.z;
        i_vec_x  <= b.v.x;
        i_vec_y  <= b.v.y;
        i_vec_z  <= b.v.z;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_stream(int count, bit use_directed);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int k = 0; k < count; k++) begin
            send_beat(use_directed ? directed_beats[k] : random_beat());
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                // Now and then a long stretch with no gaps at all.
                burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
                gap = $urandom_range(1, 7);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_quat_w <= '0;
        i_quat_x <= '0;
        i_quat_y <= '0;
        i_quat_z <= '0;
        i_vec_x  <= '0;
        i_vec_y  <= '0;
        i_vec_z  <= '0;

        add_directed(0, 0, 0, 0, 0, 0, 0);
        add_directed(UNIT, 0, 0, 0, SAT_MAX, SAT_MIN, 1);
        add_directed(UNIT, 0, 0, 0, -1, 0, SAT_MAX);
        add_directed(-UNIT, 0, 0, 0, 1000, -2000, 3000);
        add_directed(COS45, 0, 0, COS45, 10000, 0, 0);
        add_directed(COS45, COS45, 0, 0, 0, 10000, -5);
        add_directed(COS45, 0, COS45, 0, 0, 0, 10000);
        add_directed(0, UNIT, 0, 0, SAT_MAX, SAT_MAX, SAT_MIN);
        add_directed(0, 0, UNIT, 0, SAT_MIN, SAT_MIN, SAT_MIN);
        add_directed(0, 0, 0, UNIT, 12345, -23456, 7);
        add_directed(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        add_directed(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
        add_directed(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN);
        // Scale of about four: saturates at both ends.
        add_directed(SAT_MAX, 0, 0, 0, 20000, -20000, 100);
        add_directed(1, 1, 1, 1, SAT_MAX, SAT_MAX, SAT_MAX);
        // A half-unit quaternion puts both rounding steps on exact ties.
        add_directed(UNIT / 2, 0, 0, 0, 1, -1, 3);
        add_directed(-UNIT / 2, 0, 0, 0, -1, 1, -3);
        add_directed(UNIT, UNIT, UNIT, UNIT, 100, 200, 300);
        add_directed(0, 0, 0, 0, SAT_MAX, SAT_MIN, SAT_MAX);
        add_directed(-1, -1, -1, -1, SAT_MIN, SAT_MIN, SAT_MIN);
        add_directed(21845, -21846, 21845, -21846, 21845, -21846, 21845);
        add_directed(-21846, 21845, -21846, 21845, -21846, 21845, -21846);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_stream(directed_beats.size(), 1'b1);
        send_stream(1950, 1'b0);
        start <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        // Let any stray beat emerge from the four-stage pipeline.
        repeat (10) @(posedge i_clk);

        if (sb.failures() == 0)
            $display("quaternion_vector_rotate_tb OK");
        else
            $display("quaternion_vector_rotate_tb NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("quaternion_vector_rotate_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
